// ===== rtl/patch_overlap_add_blend_unit_macros.svh =====
// assertion macros for the overlap-add blend rtl
// expects clk and rst_n in the scope of the module that uses them
`ifndef PATCH_OVERLAP_ADD_BLEND_UNIT_MACROS_SVH
`define PATCH_OVERLAP_ADD_BLEND_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define POBU_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define POBU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pobu_pkg.sv =====
// types and constants of the overlap-add patch blend unit
// no dependencies; used by every rtl module of the block
package pobu_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int MAX_PATCH  = 256;

  localparam int COORD_W = 9;   // patch start and output coordinates
  localparam int OFFS_W  = 8;   // offset inside a patch
  localparam int CH_W    = 8;   // one color channel
  localparam int EXT_W   = 10;  // extents and unclipped image coordinates
  localparam int SIZE_W  = 9;   // patch size, stride, last grid start
  localparam int PIX_W   = 3 * CH_W;

  localparam int X_W    = $clog2(MAX_WIDTH);
  localparam int Y_W    = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = X_W + Y_W;
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;

  localparam int DIV_STAGES = COORD_W;  // one quotient bit per stage

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATCH_SIZE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_GRID_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_GRID_Y  = 3'd5;

  typedef struct packed {
    logic [COORD_W-1:0] patch_x;
    logic [COORD_W-1:0] patch_y;
    logic [OFFS_W-1:0]  offset_x;
    logic [OFFS_W-1:0]  offset_y;
    logic [CH_W-1:0]    blue_in;
    logic [CH_W-1:0]    green_in;
    logic [CH_W-1:0]    red_in;
  } pobu_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] image_x;
    logic [COORD_W-1:0] image_y;
    logic [CH_W-1:0]    blue_sum;
    logic [CH_W-1:0]    green_sum;
    logic [CH_W-1:0]    red_sum;
  } pobu_out_t;

  // configuration after clamping; the user must keep it stable while items are in flight, the block does not enforce it
  typedef struct packed {
    logic [EXT_W-1:0]  width;
    logic [EXT_W-1:0]  height;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] stride;
    logic [SIZE_W-1:0] last_x;
    logic [SIZE_W-1:0] last_y;
  } cfg_eff_t;

  // read-modify-write request from the coverage pipe to the frame store
  typedef struct packed {
    logic               valid;
    logic               wr;       // pixel inside patch and image
    logic [ADDR_W-1:0]  addr;
    logic [1:0]         k;        // weight is 2^-k
    logic [CH_W-1:0]    blue;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    red;
    logic [COORD_W-1:0] image_x;
    logic [COORD_W-1:0] image_y;
  } store_req_t;

endpackage

// ===== rtl/pobu_div.sv =====
// pipelined remainder unit: num mod den, one numerator bit per stage
// depends on pobu_pkg
module pobu_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [pobu_pkg::COORD_W-1:0] num,
  input  logic [pobu_pkg::SIZE_W-1:0]  den,
  output logic [pobu_pkg::SIZE_W-1:0]  rem
);
  import pobu_pkg::*;

  logic [COORD_W-1:0] num_r [DIV_STAGES-1];
  logic [SIZE_W-1:0]  rem_r [DIV_STAGES];

  // shift in one bit, subtract the divisor if it fits
  function automatic logic [SIZE_W-1:0] rem_step(input logic [SIZE_W-1:0] r,
                                                  input logic b,
                                                  input logic [SIZE_W-1:0] d);
    logic [SIZE_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) t = t - {1'b0, d};
    return t[SIZE_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      num_r[0] <= num;
      rem_r[0] <= rem_step('0, num[COORD_W-1], den);
      for (int s = 1; s < DIV_STAGES - 1; s++) num_r[s] <= num_r[s-1];
      for (int s = 1; s < DIV_STAGES; s++) begin
        rem_r[s] <= rem_step(rem_r[s-1], num_r[s-1][COORD_W-1-s], den);
      end
    end
  end

  assign rem = rem_r[DIV_STAGES-1];

endmodule

// ===== rtl/pobu_cover.sv =====
// coverage pipe: neighbor patch search per axis, blend weight, store address
// depends on pobu_pkg and pobu_div
module pobu_cover (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_take,
  input  pobu_pkg::pobu_in_t   in_data,
  input  pobu_pkg::cfg_eff_t   cfg,
  output pobu_pkg::store_req_t req
);
  import pobu_pkg::*;

  typedef struct packed {
    logic [EXT_W-1:0]   i;
    logic [COORD_W-1:0] p;
    logic               has_prev;
    logic [EXT_W-1:0]   prev;
    logic               has_next;
    logic [EXT_W-1:0]   next;
  } axis_t;

  typedef struct packed {
    axis_t           ax;
    axis_t           ay;
    logic            ok;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } c1_t;

  logic [DIV_STAGES-1:0] dv_r;
  pobu_in_t              dp_r [DIV_STAGES];
  logic [SIZE_W-1:0]     rem_x, rem_y, rem_lx, rem_ly;
  logic [EXT_W-1:0]      top_x, top_y;
  c1_t                   c1_nxt, c1_r;
  logic                  c1_v_r;
  store_req_t            req_nxt, req_r;
  logic                  sh_x, sh_y;
  pobu_in_t              dl;

  // grid neighbors from p mod stride, clipped to the last grid start
  function automatic axis_t grid_nbrs(input logic [COORD_W-1:0] p,
                                      input logic [OFFS_W-1:0] o,
                                      input logic [SIZE_W-1:0] r,
                                      input logic [SIZE_W-1:0] st,
                                      input logic [EXT_W-1:0] top);
    axis_t            a;
    logic [EXT_W-1:0] base, prevq;
    base       = EXT_W'(p) - EXT_W'(r);
    prevq      = (r != '0) ? base : base - EXT_W'(st);
    a.i        = EXT_W'(p) + EXT_W'(o);
    a.p        = p;
    a.has_prev = (p != '0);
    a.prev     = (prevq > top) ? top : prevq;
    a.next     = base + EXT_W'(st);
    a.has_next = (a.next <= top);
    return a;
  endfunction

  // merge the edge-flush patch and test overlap with either neighbor
  function automatic logic shared(input axis_t a, input logic [EXT_W-1:0] ext,
                                  input logic [SIZE_W-1:0] sz);
    logic             hp, hn;
    logic [EXT_W-1:0] pv, nx, f, p10, sz10;
    hp   = a.has_prev;
    hn   = a.has_next;
    pv   = a.prev;
    nx   = a.next;
    p10  = EXT_W'(a.p);
    sz10 = EXT_W'(sz);
    f    = ext - sz10;
    if (sz10 <= ext) begin
      if (f < p10 && (!hp || f > pv)) begin
        pv = f;
        hp = 1'b1;
      end
      if (f > p10 && (!hn || f < nx)) begin
        nx = f;
        hn = 1'b1;
      end
    end
    return (hp && a.i < pv + sz10) || (hn && a.i >= nx);
  endfunction

  pobu_div u_div_x (.clk(clk), .en(adv), .num(in_data.patch_x), .den(cfg.stride),
                    .rem(rem_x));
  pobu_div u_div_y (.clk(clk), .en(adv), .num(in_data.patch_y), .den(cfg.stride),
                    .rem(rem_y));
  // last grid starts are static, so these run freely
  pobu_div u_div_lx (.clk(clk), .en(1'b1), .num(cfg.last_x), .den(cfg.stride),
                     .rem(rem_lx));
  pobu_div u_div_ly (.clk(clk), .en(1'b1), .num(cfg.last_y), .den(cfg.stride),
                     .rem(rem_ly));

  assign dl    = dp_r[DIV_STAGES-1];
  assign top_x = EXT_W'(cfg.last_x) - EXT_W'(rem_lx);
  assign top_y = EXT_W'(cfg.last_y) - EXT_W'(rem_ly);

  always_comb begin
    c1_nxt.ax    = grid_nbrs(dl.patch_x, dl.offset_x, rem_x, cfg.stride, top_x);
    c1_nxt.ay    = grid_nbrs(dl.patch_y, dl.offset_y, rem_y, cfg.stride, top_y);
    c1_nxt.ok    = (EXT_W'(dl.offset_x) < EXT_W'(cfg.size)) &&
                   (EXT_W'(dl.offset_y) < EXT_W'(cfg.size)) &&
                   (c1_nxt.ax.i < cfg.width) && (c1_nxt.ay.i < cfg.height);
    c1_nxt.blue  = dl.blue_in;
    c1_nxt.green = dl.green_in;
    c1_nxt.red   = dl.red_in;
  end

  always_comb begin
    sh_x            = shared(c1_r.ax, cfg.width, cfg.size);
    sh_y            = shared(c1_r.ay, cfg.height, cfg.size);
    req_nxt.valid   = c1_v_r;
    req_nxt.wr      = c1_r.ok;
    req_nxt.addr    = {c1_r.ay.i[Y_W-1:0], c1_r.ax.i[X_W-1:0]};
    req_nxt.k       = {1'b0, sh_x} + {1'b0, sh_y};
    req_nxt.blue    = c1_r.blue;
    req_nxt.green   = c1_r.green;
    req_nxt.red     = c1_r.red;
    req_nxt.image_x = c1_r.ax.i[COORD_W-1:0];
    req_nxt.image_y = c1_r.ay.i[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r   <= '0;
      c1_v_r <= 1'b0;
      req_r  <= '0;
    end else if (adv) begin
      dv_r   <= {dv_r[DIV_STAGES-2:0], in_take};
      c1_v_r <= dv_r[DIV_STAGES-1];
      req_r  <= req_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dp_r[0] <= in_data;
      for (int s = 1; s < DIV_STAGES; s++) dp_r[s] <= dp_r[s-1];
      c1_r <= c1_nxt;
    end
  end

  assign req = req_r;

endmodule

// ===== rtl/pobu_store.sv =====
// frame store: clearing pass, read-modify-write with forwarding, saturating add
// depends on pobu_pkg and the assertion macro header
`include "patch_overlap_add_blend_unit_macros.svh"

module pobu_store (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  pobu_pkg::store_req_t req,
  output logic                 clear_busy,
  output logic                 m_valid,
  output pobu_pkg::pobu_out_t  m_data
);
  import pobu_pkg::*;

  logic [PIX_W-1:0]  mem [DEPTH];
  logic              clear_busy_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic              m_valid_r;
  store_req_t        m_req_r;
  logic [PIX_W-1:0]  rd_data_r, fwd_data_r;
  logic              fwd_hit_r;
  logic [PIX_W-1:0]  base, new_pix;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [PIX_W-1:0]  wr_data;

  // weight 2^-k with round half to even
  function automatic logic [CH_W-1:0] scale_round(input logic [CH_W-1:0] v,
                                                  input logic [1:0] k);
    logic [CH_W-1:0] q;
    logic            up;
    unique case (k)
      2'd1: begin
        q  = v >> 1;
        up = v[0] && q[0];
      end
      2'd2: begin
        q  = v >> 2;
        up = (v[1:0] == 2'b11) || (v[1:0] == 2'b10 && q[0]);
      end
      default: begin
        q  = v;
        up = 1'b0;
      end
    endcase
    return q + CH_W'(up);
  endfunction

  function automatic logic [CH_W-1:0] sat_add(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    logic [CH_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CH_W] ? {CH_W{1'b1}} : s[CH_W-1:0];
  endfunction

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_busy_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clear_busy_r) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (&clr_addr_r) clear_busy_r <= 1'b0;
    end
  end

  // pixel layout: blue high, red low
  assign base = fwd_hit_r ? fwd_data_r : rd_data_r;
  assign new_pix = {sat_add(base[3*CH_W-1:2*CH_W], scale_round(m_req_r.blue, m_req_r.k)),
                    sat_add(base[2*CH_W-1:CH_W], scale_round(m_req_r.green, m_req_r.k)),
                    sat_add(base[CH_W-1:0], scale_round(m_req_r.red, m_req_r.k))};

  assign wr_en   = clear_busy_r || (adv && m_valid_r && m_req_r.wr);
  assign wr_addr = clear_busy_r ? clr_addr_r : m_req_r.addr;
  assign wr_data = clear_busy_r ? '0 : new_pix;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (adv) rd_data_r <= mem[req.addr];
  end

  // the read issued on this edge misses the write on the same edge: forward it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else if (adv) begin
      m_valid_r <= req.valid;
      fwd_hit_r <= req.valid && req.wr && m_valid_r && m_req_r.wr &&
                   (req.addr == m_req_r.addr);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_req_r    <= req;
      fwd_data_r <= new_pix;
    end
  end

  assign clear_busy       = clear_busy_r;
  assign m_valid          = m_valid_r;
  assign m_data.image_x   = m_req_r.image_x;
  assign m_data.image_y   = m_req_r.image_y;
  assign m_data.blue_sum  = m_req_r.wr ? new_pix[3*CH_W-1:2*CH_W] : '0;
  assign m_data.green_sum = m_req_r.wr ? new_pix[2*CH_W-1:CH_W] : '0;
  assign m_data.red_sum   = m_req_r.wr ? new_pix[CH_W-1:0] : '0;

  `POBU_ASSERT_IMPLY(a_no_item_while_clearing, clear_busy_r, !m_valid_r, "item in store during clear")
  `POBU_ASSERT_IMPLY(a_fwd_needs_writer, fwd_hit_r, m_valid_r && m_req_r.wr, "forward without writer")
  `POBU_ASSERT_NEXT(a_stall_holds_item, !adv && m_valid_r, m_valid_r && $stable(m_req_r.addr), "stalled item moved")
  `POBU_ASSERT_IMPLY(a_clear_wraps, $fell(clear_busy_r), clr_addr_r == '0, "clear pass ended early")

endmodule

// ===== rtl/patch_overlap_add_blend_unit.sv =====
// overlap-add patch blend unit: one item per clock while in_ready is high
// the accept edge loads the first stride remainder stage, the remaining remainder stages finish it,
// then the item passes the neighbor search registers, the store read register and the output register
// reset: registers take their defaults and the frame store is cleared in a pass over
// the whole store (one pixel per cycle) with in_ready low; cfg writes still taken
// depends on pobu_pkg, pobu_cover, pobu_store
module patch_overlap_add_blend_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pobu_pkg::pobu_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output pobu_pkg::pobu_out_t             out_data,
  input  logic                            cfg_we,
  input  logic [pobu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pobu_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pobu_pkg::*;

  localparam logic [EXT_W-1:0]  WIDTH_RST  = 10'd512;
  localparam logic [EXT_W-1:0]  HEIGHT_RST = 10'd512;
  localparam logic [SIZE_W-1:0] PATCH_RST  = 9'd128;
  localparam logic [SIZE_W-1:0] STRIDE_RST = 9'd64;

  // configuration registers
  logic [EXT_W-1:0]  img_w_r, img_h_r;
  logic [SIZE_W-1:0] patch_r, stride_r, last_x_r, last_y_r;
  cfg_eff_t          cfg;

  // pipe control
  logic       adv;
  logic       in_take;
  store_req_t req;
  logic       clear_busy;
  logic       m_valid;
  pobu_out_t  m_data;
  logic       out_valid_r;
  pobu_out_t  out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r  <= WIDTH_RST;
      img_h_r  <= HEIGHT_RST;
      patch_r  <= PATCH_RST;
      stride_r <= STRIDE_RST;
      last_x_r <= '0;
      last_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  img_w_r  <= cfg_wdata;
        CFG_IMAGE_HEIGHT: img_h_r  <= cfg_wdata;
        CFG_PATCH_SIZE:   patch_r  <= cfg_wdata[SIZE_W-1:0];
        CFG_STRIDE:       stride_r <= cfg_wdata[SIZE_W-1:0];
        CFG_LAST_GRID_X:  last_x_r <= cfg_wdata[SIZE_W-1:0];
        CFG_LAST_GRID_Y:  last_y_r <= cfg_wdata[SIZE_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // clamp to the store size and the largest patch; a zero stride acts as one
  always_comb begin
    cfg.width  = (img_w_r > EXT_W'(MAX_WIDTH)) ? EXT_W'(MAX_WIDTH) : img_w_r;
    cfg.height = (img_h_r > EXT_W'(MAX_HEIGHT)) ? EXT_W'(MAX_HEIGHT) : img_h_r;
    cfg.size   = (patch_r > SIZE_W'(MAX_PATCH)) ? SIZE_W'(MAX_PATCH) : patch_r;
    cfg.stride = (stride_r == '0) ? SIZE_W'(1) : stride_r;
    cfg.last_x = last_x_r;
    cfg.last_y = last_y_r;
  end

  // the whole pipe moves together; it only halts when the last stage holds an
  // item and the output register is full and not being drained, so bubbles
  // keep absorbing new items while a result waits
  assign adv      = !(m_valid && out_valid_r && !out_ready);
  assign in_ready = !clear_busy && adv;
  assign in_take  = in_valid && in_ready;

  pobu_cover u_cover (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_take (in_take),
    .in_data (in_data),
    .cfg     (cfg),
    .req     (req)
  );

  pobu_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .req        (req),
    .clear_busy (clear_busy),
    .m_valid    (m_valid),
    .m_data     (m_data)
  );

  // output register, loads whenever the last stage moves an item out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && m_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && m_valid) out_data_r <= m_data;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/sv/patch_overlap_add_blend_unit_checker.sv =====
// scoreboard for the overlap-add patch blend unit: follows register writes,
// predicts every blended pixel against its own frame copy and compares results
// depends on pobu_pkg
module patch_overlap_add_blend_unit_checker
  import pobu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  pobu_in_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  pobu_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    pixels_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_MAX = 30;

  logic [EXT_W-1:0]  width_r;
  logic [EXT_W-1:0]  height_r;
  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] stride_r;
  logic [SIZE_W-1:0] last_x_r;
  logic [SIZE_W-1:0] last_y_r;

  logic [PIX_W-1:0]  frame_copy [int];   // absent entry reads as cleared
  pobu_out_t         predicted_pixels [$];

  // neighbor coverage on one axis
  function automatic bit axis_overlapped(int unsigned start, int unsigned coord,
      int unsigned extent, int unsigned side, int unsigned step, int unsigned last_grid);
    int unsigned top_start, below, above, cand;
    bit has_below, has_above;
    top_start = (last_grid / step) * step;
    has_below = 1'b0;
    has_above = 1'b0;
    below = 0;
    above = 0;
    if (start > 0) begin
      cand = ((start - 1) / step) * step;
      below = (cand > top_start) ? top_start : cand;
      has_below = 1'b1;
    end
    cand = (start / step + 1) * step;
    if (cand <= top_start) begin
      above = cand;
      has_above = 1'b1;
    end
    // edge-flush patch
    if (side <= extent) begin
      cand = extent - side;
      if (cand < start && (!has_below || cand > below)) begin
        below = cand;
        has_below = 1'b1;
      end
      if (cand > start && (!has_above || cand < above)) begin
        above = cand;
        has_above = 1'b1;
      end
    end
    return (has_below && coord < below + side) || (has_above && coord >= above);
  endfunction

  // v * 2^-k, round half to even
  function automatic logic [CH_W-1:0] weighted_channel(logic [CH_W-1:0] v, int k);
    logic [CH_W-1:0] q, r, half;
    if (k == 0) return v;
    q = v >> k;
    r = v & ((8'd1 << k) - 8'd1);
    half = 8'd1 << (k - 1);
    if (r > half || (r == half && q[0])) q = q + 8'd1;
    return q;
  endfunction

  function automatic pobu_out_t blend_pixel(pobu_in_t px);
    pobu_out_t        res;
    int unsigned      ext_w, ext_h, side, step, col, row, addr, sum;
    int               k, c;
    logic [PIX_W-1:0] stored, chans;
    ext_w = (width_r < MAX_WIDTH) ? width_r : MAX_WIDTH;
    ext_h = (height_r < MAX_HEIGHT) ? height_r : MAX_HEIGHT;
    side  = (size_r < MAX_PATCH) ? size_r : MAX_PATCH;
    step  = (stride_r == 0) ? 1 : stride_r;
    col   = px.patch_x + px.offset_x;
    row   = px.patch_y + px.offset_y;
    res = '0;
    res.image_x = COORD_W'(col);
    res.image_y = COORD_W'(row);
    if (px.offset_x < side && px.offset_y < side && col < ext_w && row < ext_h) begin
      k = 0;
      if (axis_overlapped(px.patch_x, col, ext_w, side, step, last_x_r)) k++;
      if (axis_overlapped(px.patch_y, row, ext_h, side, step, last_y_r)) k++;
      addr = row * MAX_WIDTH + col;
      stored = frame_copy.exists(addr) ? frame_copy[addr] : '0;
      chans = {px.blue_in, px.green_in, px.red_in};
      for (c = 0; c < 3; c++) begin
        sum = stored[PIX_W-1-c*CH_W -: CH_W] +
              weighted_channel(chans[PIX_W-1-c*CH_W -: CH_W], k);
        if (sum > 255) sum = 255;
        stored[PIX_W-1-c*CH_W -: CH_W] = CH_W'(sum);
      end
      frame_copy[addr] = stored;
      {res.blue_sum, res.green_sum, res.red_sum} = stored;
    end
    return res;
  endfunction

  function automatic void check_field(string field, logic [COORD_W-1:0] want,
                                      logic [COORD_W-1:0] got);
    if (got !== want) begin
      if (mismatch_count < REPORT_MAX)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : track
    pobu_out_t want;
    if (!rst_n) begin
      width_r  = EXT_W'(512);
      height_r = EXT_W'(512);
      size_r   = SIZE_W'(128);
      stride_r = SIZE_W'(64);
      last_x_r = '0;
      last_y_r = '0;
      frame_copy.delete();
      predicted_pixels.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  width_r  = cfg_wdata[EXT_W-1:0];
          CFG_IMAGE_HEIGHT: height_r = cfg_wdata[EXT_W-1:0];
          CFG_PATCH_SIZE:   size_r   = cfg_wdata[SIZE_W-1:0];
          CFG_STRIDE:       stride_r = cfg_wdata[SIZE_W-1:0];
          CFG_LAST_GRID_X:  last_x_r = cfg_wdata[SIZE_W-1:0];
          CFG_LAST_GRID_Y:  last_y_r = cfg_wdata[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        predicted_pixels.insert(predicted_pixels.size(), blend_pixel(in_data));
      if (out_valid && out_ready) begin
        if (predicted_pixels.size() == 0) begin
          if (mismatch_count < REPORT_MAX)
            $display("%0t ns: unexpected result, expected none, actual %h", $time, out_data);
          mismatch_count++;
        end else begin
          want = predicted_pixels.pop_front();
          check_field("image_x", want.image_x, out_data.image_x);
          check_field("image_y", want.image_y, out_data.image_y);
          check_field("blue_sum", want.blue_sum, out_data.blue_sum);
          check_field("green_sum", want.green_sum, out_data.green_sum);
          check_field("red_sum", want.red_sum, out_data.red_sum);
        end
      end
    end
    pixels_outstanding = predicted_pixels.size();
  end

endmodule

// ===== tb/sv/patch_overlap_add_blend_unit_tb.sv =====
// testbench top for the overlap-add patch blend unit: clock, reset, register
// settings, pixel stimulus and the verdict; checking lives in the checker module
// depends on pobu_pkg, patch_overlap_add_blend_unit, patch_overlap_add_blend_unit_checker
module patch_overlap_add_blend_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pobu_pkg::*;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 7;
  localparam int PIPE_LATENCY    = 12;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int RANDOM_SETTINGS = 4;
  // covers the clear pass after reset plus a stall-heavy run, many times over
  localparam int CYCLE_LIMIT     = 1_500_000;
  // index with no register behind it, writes must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_LONG} rx_mode_t;

  typedef struct {
    int w, h, side, step, last_x, last_y;
  } blend_setting_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  pobu_in_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  pobu_out_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatch_count;
  int                    pixels_outstanding;

  // stimulus view of the current setting
  int             ext_w, ext_h, side_eff, step_eff;
  int             starts_x[$], starts_y[$];
  bit             bursty;
  int             burst_left;
  rx_mode_t       rx_mode;
  int             rx_tick, rx_hold;
  int             cycle_count;
  blend_setting_t plan[$];

  always #(HALF_PERIOD) clk = ~clk;

  patch_overlap_add_blend_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  patch_overlap_add_blend_unit_checker u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data            (in_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_data           (out_data),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .mismatch_count     (mismatch_count),
    .pixels_outstanding (pixels_outstanding)
  );

  // run guard, also catches results that never come back
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side back-pressure, one pattern per phase
  always @(negedge clk) begin
    case (rx_mode)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_RANDOM: out_ready <= ($urandom_range(0, 9) < 7);
      RX_PATTERN: begin
        // low while rx_tick mod 8 is below three, high otherwise
        rx_tick++;
        out_ready <= (rx_tick % 8) >= 3;
      end
      default: begin
        // mostly ready with occasional long stalls
        if (rx_hold > 0) begin
          rx_hold--;
          out_ready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          rx_hold = $urandom_range(4, 24);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, int data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(data);
    @(negedge clk);
  endtask

  // append one register setting to the run plan
  function automatic void add_setting(int w, int h, int side, int step, int lx, int ly);
    blend_setting_t s;
    s.w      = w;
    s.h      = h;
    s.side   = side;
    s.step   = step;
    s.last_x = lx;
    s.last_y = ly;
    plan.insert(plan.size(), s);
  endfunction

  // patch starts on one axis: stride grid up to the last grid start, then the flush patch
  function automatic void list_starts(int extent, int last_grid, ref int q[$]);
    q.delete();
    for (int s = 0; s <= (last_grid / step_eff) * step_eff; s += step_eff)
      q.insert(q.size(), s);
    if (side_eff > 0 && side_eff <= extent) q.insert(q.size(), extent - side_eff);
  endfunction

  task automatic apply_setting(blend_setting_t s);
    put_reg(CFG_IMAGE_WIDTH, s.w);
    put_reg(CFG_IMAGE_HEIGHT, s.h);
    put_reg(CFG_PATCH_SIZE, s.side);
    put_reg(CFG_STRIDE, s.step);
    put_reg(CFG_LAST_GRID_X, s.last_x);
    put_reg(CFG_LAST_GRID_Y, s.last_y);
    put_reg(CFG_UNUSED, $urandom);
    cfg_we <= 1'b0;
    // the same clamping the block applies, so streams land where patches really are
    ext_w    = (s.w < MAX_WIDTH) ? s.w : MAX_WIDTH;
    ext_h    = (s.h < MAX_HEIGHT) ? s.h : MAX_HEIGHT;
    side_eff = (s.side < MAX_PATCH) ? s.side : MAX_PATCH;
    step_eff = (s.step == 0) ? 1 : s.step;
    list_starts(ext_w, s.last_x, starts_x);
    list_starts(ext_h, s.last_y, starts_y);
  endtask

  // send one item, then maybe open a gap between bursts
  task automatic push_pixel(pobu_in_t px);
    int gap;
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
    if (bursty) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 24);
        gap = $urandom_range(1, 8);
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // small values exercise rounding, values near the top exercise saturation
  function automatic logic [CH_W-1:0] pick_channel();
    case ($urandom_range(0, 3))
      0:       return CH_W'($urandom_range(0, 3));
      1:       return CH_W'($urandom_range(252, 255));
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic aim(int px_x, int px_y, int ox, int oy, int b, int g, int r);
    pobu_in_t px;
    px.patch_x  = COORD_W'(px_x);
    px.patch_y  = COORD_W'(px_y);
    px.offset_x = OFFS_W'(ox);
    px.offset_y = OFFS_W'(oy);
    px.blue_in  = CH_W'(b);
    px.green_in = CH_W'(g);
    px.red_in   = CH_W'(r);
    push_pixel(px);
  endtask

  task automatic run_phase(int count);
    pobu_in_t px;
    int sent, pick, span, col0, run;
    sent = 0;
    span = (side_eff > 0) ? side_eff : 1;
    while (sent < count) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        // row segment of a real patch, as the upscaler streams it
        px.patch_x  = COORD_W'(starts_x[$urandom_range(0, starts_x.size() - 1)]);
        px.patch_y  = COORD_W'(starts_y[$urandom_range(0, starts_y.size() - 1)]);
        px.offset_y = OFFS_W'($urandom_range(0, span - 1));
        col0 = $urandom_range(0, span - 1);
        run  = $urandom_range(1, 12);
        for (int j = 0; j < run && col0 + j < span && sent < count; j++) begin
          px.offset_x = OFFS_W'(col0 + j);
          px.blue_in  = pick_channel();
          px.green_in = pick_channel();
          px.red_in   = pick_channel();
          push_pixel(px);
          sent++;
        end
      end else if (pick < 17) begin
        // patch start off the grid, still inside the image
        px.patch_x  = COORD_W'($urandom_range(0, ext_w - 1));
        px.patch_y  = COORD_W'($urandom_range(0, ext_h - 1));
        px.offset_x = OFFS_W'($urandom_range(0, span - 1));
        px.offset_y = OFFS_W'($urandom_range(0, span - 1));
        px.blue_in  = pick_channel();
        px.green_in = pick_channel();
        px.red_in   = pick_channel();
        push_pixel(px);
        sent++;
      end else begin
        // anything the fields can carry
        px.patch_x  = COORD_W'($urandom);
        px.patch_y  = COORD_W'($urandom);
        px.offset_x = OFFS_W'($urandom);
        px.offset_y = OFFS_W'($urandom);
        px.blue_in  = CH_W'($urandom);
        px.green_in = CH_W'($urandom);
        px.red_in   = CH_W'($urandom);
        push_pixel(px);
        sent++;
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    int w, h, side;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    bursty      = 1'b0;
    burst_left  = 0;
    rx_mode     = RX_ALWAYS;
    rx_tick     = 0;
    rx_hold     = 0;
    cycle_count = 0;

    // directed setting first, then extremes and corner settings, then random ones
    add_setting(64, 48, 16, 8, 40, 24);
    add_setting(512, 512, 128, 64, 0, 0);        // reset values, written back
    add_setting(1, 1, 2, 1, 0, 0);               // smallest image
    add_setting(1023, 1023, 511, 511, 511, 511); // oversized registers get clamped
    add_setting(100, 80, 20, 0, 60, 50);         // zero stride acts as one
    add_setting(40, 30, 64, 16, 16, 8);          // patch wider than the image
    add_setting(512, 512, 256, 256, 256, 256);   // largest patch, no overlap
    add_setting(96, 96, 0, 4, 64, 64);           // zero patch size, nothing stored
    add_setting(512, 300, 32, 8, 480, 268);      // dense overlap
    for (int i = 0; i < RANDOM_SETTINGS; i++) begin
      w    = $urandom_range(16, 512);
      h    = $urandom_range(16, 512);
      side = $urandom_range(2, (w < h ? w : h) < 256 ? (w < h ? w : h) : 256);
      add_setting(w, h, side, $urandom_range(1, side), $urandom_range(0, w - side),
                  $urandom_range(0, h - side));
    end

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < plan.size(); ph++) begin
      // registers only change with nothing in flight
      apply_setting(plan[ph]);
      bursty  = (ph % 3 != 1);
      rx_mode = rx_mode_t'(ph % 4);
      if (ph == 0) begin
        aim(0, 0, 0, 0, 1, 2, 3);               // first grid patch, no neighbor behind
        aim(8, 8, 0, 0, 2, 6, 3);               // quarter weight, ties to even
        aim(8, 0, 4, 4, 1, 3, 5);               // half weight on x only
        aim(48, 32, 15, 15, 255, 255, 255);     // flush patch, bottom-right image corner
        aim(48, 32, 15, 15, 255, 128, 1);       // same pixel again, saturates
        aim(40, 24, 15, 15, 200, 100, 50);      // last grid patch reaching into the flush one
        aim(8, 32, 3, 10, 7, 7, 7);             // flush row, shared column
        aim(16, 16, 16, 0, 9, 9, 9);            // offset just past the patch
        aim(60, 8, 8, 0, 9, 9, 9);              // pixel right of the image
        aim(13, 5, 3, 3, 77, 88, 99);           // start off the grid
        aim(511, 511, 255, 255, 255, 255, 255); // every field at its top
        aim(0, 0, 0, 0, 0, 0, 0);               // all zero
        aim(24, 16, 7, 9, 8'hAA, 8'h55, 8'hAA);
        aim(32, 0, 5, 0, 8'h55, 8'hAA, 8'h55);
        in_valid <= 1'b0;
      end else begin
        run_phase(ITEMS_PER_PHASE);
      end
      while (pixels_outstanding != 0) @(negedge clk);
      repeat (PIPE_LATENCY) @(negedge clk);
    end

    repeat (PIPE_LATENCY) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
